### rtl/fvnh_pkg.sv
package fvnh_pkg;

    // field widths
    localparam int COORD_W     = 24;
    localparam int HEIGHT_W    = 9;
    localparam int SEED_W      = 32;
    localparam int ZOOM_W      = 10;
    localparam int LATTICE_W   = 32;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [HEIGHT_W-1:0] height_t;
    typedef logic [LATTICE_W-1:0]       lattice_t;
    typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;

    // register indexes
    localparam cfg_index_t REG_NOISE_SEED   = 4'd0;
    localparam cfg_index_t REG_ZOOM_DIVISOR = 4'd1;

    localparam logic [SEED_W-1:0] SEED_RESET = 32'd0;
    localparam logic [ZOOM_W-1:0] ZOOM_RESET = 10'd64;

    // lattice hash, kept to the 31 bits that survive the final mask
    localparam int HASH_W     = 31;
    localparam int HASH_SHIFT = 13;
    localparam logic [HASH_W-1:0] HASH_ROW_MUL = 31'd57;
    localparam logic [HASH_W-1:0] HASH_MUL_A   = 31'd60493;
    localparam logic [HASH_W-1:0] HASH_ADD_A   = 31'd19990303;
    localparam logic [HASH_W-1:0] HASH_ADD_B   = 31'd1376312589;
    localparam logic signed [31:0] HASH_ONE    = 32'sh4000_0000;
    localparam int HASH_FRAC   = 30;

    // pipeline depth of one octave unit
    localparam int OCT_LATENCY = 9;

    // height saturation limits
    localparam int HEIGHT_MAX = 255;
    localparam int HEIGHT_MIN = -256;

endpackage

### rtl/fvnh_split.sv
module fvnh_split #(
    parameter int OCTAVE_COUNT  = 5,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  fvnh_pkg::coord_t              in_x,
    input  fvnh_pkg::coord_t              in_z,
    input  logic [fvnh_pkg::ZOOM_W-1:0]   zoom,
    output logic                          out_valid,
    output fvnh_pkg::lattice_t            ix [OCTAVE_COUNT],
    output fvnh_pkg::lattice_t            iz [OCTAVE_COUNT],
    output logic signed [FRACTION_BITS:0] fx [OCTAVE_COUNT],
    output logic signed [FRACTION_BITS:0] fz [OCTAVE_COUNT]
);
    import fvnh_pkg::*;

    // quotient of |c| * 2^(octaves-1) / zoom, one bit a stage
    localparam int MAG_W = COORD_W;
    localparam int QUO_W = MAG_W + OCTAVE_COUNT - 1;
    localparam int DEPTH = QUO_W + FRACTION_BITS;

    typedef struct packed {
        logic [QUO_W-1:0]                            acc;
        logic [ZOOM_W-1:0]                           rem;
        logic [OCTAVE_COUNT-1:0][ZOOM_W-1:0]         lrem;
        logic [OCTAVE_COUNT-1:0][FRACTION_BITS-1:0]  lfr;
        logic                                        neg;
    } split_state_t;

    split_state_t st_first [2];
    split_state_t st_in    [DEPTH][2];
    split_state_t st_next  [DEPTH][2];
    split_state_t st_reg   [DEPTH][2];
    logic         vld_reg  [DEPTH];
    logic [MAG_W-1:0] mag [2];

    // sign and magnitude of the incoming coordinates
    always_comb
    begin
        mag[0] = in_x[COORD_W-1] ? MAG_W'(-in_x) : MAG_W'(in_x);
        mag[1] = in_z[COORD_W-1] ? MAG_W'(-in_z) : MAG_W'(in_z);
        for (int c = 0; c < 2; c++)
        begin
            st_first[c].acc  = QUO_W'(mag[c]) << (OCTAVE_COUNT - 1);
            st_first[c].rem  = '0;
            st_first[c].lrem = '0;
            st_first[c].lfr  = '0;
        end
        st_first[0].neg = in_x[COORD_W-1];
        st_first[1].neg = in_z[COORD_W-1];
    end

    for (genvar j = 0; j < DEPTH; j++)
    begin : g_stage
        for (genvar c = 0; c < 2; c++)
        begin : g_coord
            if (j == 0)
            begin : g_head
                assign st_in[j][c] = st_first[c];
            end
            else
            begin : g_body
                assign st_in[j][c] = st_reg[j-1][c];
            end

            // one restoring step on the main quotient and on each active lane
            always_comb
            begin
                logic [ZOOM_W:0]   trial;
                logic [ZOOM_W-1:0] lr;
                logic              qbit;
                st_next[j][c] = st_in[j][c];
                trial = '0;
                lr    = '0;
                qbit  = 1'b0;
                if (j < QUO_W)
                begin
                    trial = {st_in[j][c].rem, st_in[j][c].acc[QUO_W-1]};
                    qbit  = (trial >= {1'b0, zoom});
                    if (qbit)
                    begin
                        st_next[j][c].rem = ZOOM_W'(trial - {1'b0, zoom});
                    end
                    else
                    begin
                        st_next[j][c].rem = ZOOM_W'(trial);
                    end
                    st_next[j][c].acc = {st_in[j][c].acc[QUO_W-2:0], qbit};
                end
                for (int k = 0; k < OCTAVE_COUNT; k++)
                begin
                    if ((j >= MAG_W + k) && (j < MAG_W + k + FRACTION_BITS))
                    begin
                        lr    = (j == MAG_W + k) ? st_in[j][c].rem : st_in[j][c].lrem[k];
                        trial = {lr, 1'b0};
                        qbit  = (trial >= {1'b0, zoom});
                        if (qbit)
                        begin
                            st_next[j][c].lrem[k] = ZOOM_W'(trial - {1'b0, zoom});
                        end
                        else
                        begin
                            st_next[j][c].lrem[k] = ZOOM_W'(trial);
                        end
                        st_next[j][c].lfr[k] = {st_in[j][c].lfr[k][FRACTION_BITS-2:0], qbit};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                st_reg[j][c] <= st_next[j][c];
            end
        end

        // valid travels with the stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (j == 0)
            begin
                vld_reg[j] <= in_valid;
            end
            else
            begin
                vld_reg[j] <= vld_reg[(j == 0) ? 0 : j-1];
            end
        end
    end

    // signed lattice index and fraction per octave
    logic out_valid_reg;
    fvnh_pkg::lattice_t ix_reg [OCTAVE_COUNT];
    fvnh_pkg::lattice_t iz_reg [OCTAVE_COUNT];
    logic signed [FRACTION_BITS:0] fx_reg [OCTAVE_COUNT];
    logic signed [FRACTION_BITS:0] fz_reg [OCTAVE_COUNT];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < OCTAVE_COUNT; k++)
        begin
            ix_reg[k] <= st_reg[DEPTH-1][0].neg
                ? -LATTICE_W'(st_reg[DEPTH-1][0].acc >> (OCTAVE_COUNT - 1 - k))
                :  LATTICE_W'(st_reg[DEPTH-1][0].acc >> (OCTAVE_COUNT - 1 - k));
            iz_reg[k] <= st_reg[DEPTH-1][1].neg
                ? -LATTICE_W'(st_reg[DEPTH-1][1].acc >> (OCTAVE_COUNT - 1 - k))
                :  LATTICE_W'(st_reg[DEPTH-1][1].acc >> (OCTAVE_COUNT - 1 - k));
            fx_reg[k] <= st_reg[DEPTH-1][0].neg
                ? -$signed({1'b0, st_reg[DEPTH-1][0].lfr[k]})
                :  $signed({1'b0, st_reg[DEPTH-1][0].lfr[k]});
            fz_reg[k] <= st_reg[DEPTH-1][1].neg
                ? -$signed({1'b0, st_reg[DEPTH-1][1].lfr[k]})
                :  $signed({1'b0, st_reg[DEPTH-1][1].lfr[k]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign ix = ix_reg;
    assign iz = iz_reg;
    assign fx = fx_reg;
    assign fz = fz_reg;

endmodule

### rtl/fvnh_octave.sv
module fvnh_octave #(
    parameter int OCTAVE_INDEX      = 0,
    parameter int FRACTION_BITS     = 16,
    parameter int COS_TABLE_ENTRIES = 256
) (
    input  logic                           clk,
    input  fvnh_pkg::lattice_t             ix,
    input  fvnh_pkg::lattice_t             iz,
    input  logic signed [FRACTION_BITS:0]  fx,
    input  logic signed [FRACTION_BITS:0]  fz,
    input  logic [fvnh_pkg::SEED_W-1:0]    seed,
    output logic signed [FRACTION_BITS+1:0] value
);
    import fvnh_pkg::*;

    localparam int VAL_W    = FRACTION_BITS + 2;
    localparam int DIFF_W   = VAL_W + 1;
    localparam int W_W      = FRACTION_BITS + 1;
    localparam int PROD_W   = DIFF_W + W_W + 1;
    localparam int IDX_W    = $clog2(COS_TABLE_ENTRIES);
    localparam int SCALE_W  = FRACTION_BITS + IDX_W + 1;
    localparam int XW_DELAY = 5;
    localparam int ZW_DELAY = 7;

    // sin^2 weight, Q30 series then rounded to the fraction width
    function automatic logic [W_W-1:0] weight_entry(input int unsigned i);
        longint unsigned u;
        longint unsigned u2;
        longint unsigned term;
        longint unsigned f;
        longint          s;
        u    = (64'd1686629713 * 64'(i)) / COS_TABLE_ENTRIES;
        u2   = (u * u) >> 30;
        term = u;
        s    = longint'(u);
        term = ((term * u2) >> 30) / 6;   s = s - longint'(term);
        term = ((term * u2) >> 30) / 20;  s = s + longint'(term);
        term = ((term * u2) >> 30) / 42;  s = s - longint'(term);
        term = ((term * u2) >> 30) / 72;  s = s + longint'(term);
        term = ((term * u2) >> 30) / 110; s = s - longint'(term);
        term = ((term * u2) >> 30) / 156; s = s + longint'(term);
        if (s < 0)
        begin
            s = 0;
        end
        if (s > 64'sd1073741824)
        begin
            s = 64'sd1073741824;
        end
        f = (unsigned'(s) * unsigned'(s)) >> 30;
        return W_W'((f + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS));
    endfunction

    logic [W_W-1:0] wtab [COS_TABLE_ENTRIES];
    for (genvar i = 0; i < COS_TABLE_ENTRIES; i++)
    begin : g_wtab
        assign wtab[i] = weight_entry(i);
    end

    // blend weight lookup from the fraction magnitude
    logic [FRACTION_BITS-1:0] fx_mag, fz_mag;
    logic [SCALE_W-1:0]       fx_scaled, fz_scaled;
    logic [IDX_W-1:0]         wx_idx, wz_idx;

    assign fx_mag    = FRACTION_BITS'(fx[FRACTION_BITS] ? -fx : fx);
    assign fz_mag    = FRACTION_BITS'(fz[FRACTION_BITS] ? -fz : fz);
    assign fx_scaled = SCALE_W'(fx_mag) * SCALE_W'(COS_TABLE_ENTRIES);
    assign fz_scaled = SCALE_W'(fz_mag) * SCALE_W'(COS_TABLE_ENTRIES);
    assign wx_idx    = IDX_W'(fx_scaled >> FRACTION_BITS);
    assign wz_idx    = IDX_W'(fz_scaled >> FRACTION_BITS);

    logic [W_W-1:0] wx_reg [XW_DELAY];
    logic [W_W-1:0] wz_reg [ZW_DELAY];

    always_ff @(posedge clk)
    begin
        wx_reg[0] <= wtab[wx_idx];
        wz_reg[0] <= wtab[wz_idx];
        for (int d = 1; d < XW_DELAY; d++)
        begin
            wx_reg[d] <= wx_reg[d-1];
        end
        for (int d = 1; d < ZW_DELAY; d++)
        begin
            wz_reg[d] <= wz_reg[d-1];
        end
    end

    // corner hash, four corners side by side
    logic [HASH_W-1:0]       n1_reg [4];
    logic [HASH_W-1:0]       n2_reg [4];
    logic [HASH_W-1:0]       n3_reg [4];
    logic [HASH_W-1:0]       sq_reg [4];
    logic [HASH_W-1:0]       t_reg  [4];
    logic [HASH_W-1:0]       m_reg  [4];
    logic signed [VAL_W-1:0] corner_reg [4];

    for (genvar c = 0; c < 4; c++)
    begin : g_corner
        localparam logic [HASH_W-1:0] DX = HASH_W'(c % 2);
        localparam logic [HASH_W-1:0] DZ = HASH_W'(c / 2);

        logic [HASH_W-1:0] cx, cz, n0, n_next;
        logic signed [31:0] centred;

        always_comb
        begin
            cx      = ix[HASH_W-1:0] + DX;
            cz      = iz[HASH_W-1:0] + DZ;
            n0      = cx + HASH_W'(cz * HASH_ROW_MUL) + seed[HASH_W-1:0];
            n_next  = n0 ^ (n0 << HASH_SHIFT);
            centred = HASH_ONE - $signed({1'b0, m_reg[c]});
        end

        always_ff @(posedge clk)
        begin
            n1_reg[c]     <= n_next;
            sq_reg[c]     <= n1_reg[c] * n1_reg[c];
            n2_reg[c]     <= n1_reg[c];
            t_reg[c]      <= sq_reg[c] * HASH_MUL_A + HASH_ADD_A;
            n3_reg[c]     <= n2_reg[c];
            m_reg[c]      <= n3_reg[c] * t_reg[c] + HASH_ADD_B;
            corner_reg[c] <= VAL_W'(centred >>> (HASH_FRAC - FRACTION_BITS));
        end
    end

    // blend along x, then along z, then octave weight
    logic signed [DIFF_W-1:0] dtop, dbot, dv;
    logic signed [PROD_W-1:0] prod_top_reg, prod_bot_reg, prod_v_reg;
    logic signed [VAL_W-1:0]  base_top_reg, base_bot_reg;
    logic signed [VAL_W-1:0]  top_reg, bot_reg, top2_reg;
    logic signed [VAL_W-1:0]  blended;
    logic signed [VAL_W-1:0]  value_reg;

    always_comb
    begin
        dtop    = DIFF_W'(corner_reg[1]) - DIFF_W'(corner_reg[0]);
        dbot    = DIFF_W'(corner_reg[3]) - DIFF_W'(corner_reg[2]);
        dv      = DIFF_W'(bot_reg) - DIFF_W'(top_reg);
        blended = top2_reg + VAL_W'(prod_v_reg >>> FRACTION_BITS);
    end

    always_ff @(posedge clk)
    begin
        prod_top_reg <= PROD_W'(dtop) * PROD_W'($signed({1'b0, wx_reg[XW_DELAY-1]}));
        prod_bot_reg <= PROD_W'(dbot) * PROD_W'($signed({1'b0, wx_reg[XW_DELAY-1]}));
        base_top_reg <= corner_reg[0];
        base_bot_reg <= corner_reg[2];
        top_reg      <= base_top_reg + VAL_W'(prod_top_reg >>> FRACTION_BITS);
        bot_reg      <= base_bot_reg + VAL_W'(prod_bot_reg >>> FRACTION_BITS);
        prod_v_reg   <= PROD_W'(dv) * PROD_W'($signed({1'b0, wz_reg[ZW_DELAY-1]}));
        top2_reg     <= top_reg;
        value_reg    <= blended >>> OCTAVE_INDEX;
    end

    assign value = value_reg;

endmodule

### rtl/fvnh_sum.sv
module fvnh_sum #(
    parameter int OCTAVE_COUNT  = 5,
    parameter int FRACTION_BITS = 16,
    parameter int HEIGHT_SPAN   = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic signed [FRACTION_BITS+1:0] values [OCTAVE_COUNT],
    output logic                            done,
    output fvnh_pkg::height_t               height
);
    import fvnh_pkg::*;

    localparam int NOISE_W  = FRACTION_BITS + 5;
    localparam int SCALED_W = NOISE_W + 9;
    localparam int H_W      = SCALED_W - FRACTION_BITS - 1;
    localparam logic signed [SCALED_W-1:0] BIAS =
        SCALED_W'((64'sd1 << (FRACTION_BITS + 1)) - 64'sd1);

    logic signed [NOISE_W-1:0]  noise_next, noise_reg;
    logic signed [SCALED_W-1:0] scaled_reg, biased;
    logic signed [H_W-1:0]      h;
    height_t                    h_sat, height_reg;
    logic                       v1_reg, v2_reg, done_reg;

    // octave sum with the +1 offset
    always_comb
    begin
        noise_next = NOISE_W'(64'sd1 << FRACTION_BITS);
        for (int k = 0; k < OCTAVE_COUNT; k++)
        begin
            noise_next = noise_next + NOISE_W'(values[k]);
        end
    end

    // divide by 2^(F+1) toward zero and saturate
    always_comb
    begin
        biased = scaled_reg[SCALED_W-1] ? scaled_reg + BIAS : scaled_reg;
        h      = H_W'(biased >>> (FRACTION_BITS + 1));
        if (h > $signed(H_W'(HEIGHT_MAX)))
        begin
            h_sat = height_t'(HEIGHT_MAX);
        end
        else if (h < $signed(H_W'(HEIGHT_MIN)))
        begin
            h_sat = height_t'(HEIGHT_MIN);
        end
        else
        begin
            h_sat = HEIGHT_W'(h);
        end
    end

    always_ff @(posedge clk)
    begin
        noise_reg  <= noise_next;
        scaled_reg <= SCALED_W'(noise_reg) * $signed(SCALED_W'(HEIGHT_SPAN));
        height_reg <= h_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    assign done   = done_reg;
    assign height = height_reg;

endmodule

### rtl/fractal_value_noise_height.sv
// channel   direction  transfer when               payload
// command   in         start & !busy               column_x, column_z
// result    out        done (one cycle, no hold)   terrain_height
// config    in         cfg_valid & cfg_ready       cfg_index, cfg_data
//
// one column enters every cycle; busy never rises
// each column passes the bit-serial divider pipeline that splits each coordinate by the zoom,
// then the octave units and the sum, scale and saturate stages
// rst_n clears the valid chain and loads noise_seed = 0, zoom_divisor = 64
// the receiver cannot stall; each result is on the ports for exactly one cycle
module fractal_value_noise_height #(
    parameter int HEIGHT_SPAN       = 64,
    parameter int OCTAVE_COUNT      = 5,
    parameter int FRACTION_BITS     = 16,
    parameter int COS_TABLE_ENTRIES = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  fvnh_pkg::coord_t                 column_x,
    input  fvnh_pkg::coord_t                 column_z,
    output logic                             done,
    output fvnh_pkg::height_t                terrain_height,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  fvnh_pkg::cfg_index_t             cfg_index,
    input  logic [fvnh_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fvnh_pkg::*;

    logic [SEED_W-1:0] seed_reg;
    logic [ZOOM_W-1:0] zoom_reg;
    logic [ZOOM_W-1:0] zoom_eff;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
            zoom_reg <= ZOOM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NOISE_SEED:   seed_reg <= cfg_data[SEED_W-1:0];
                REG_ZOOM_DIVISOR: zoom_reg <= cfg_data[ZOOM_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign zoom_eff  = (zoom_reg == '0) ? ZOOM_W'(1) : zoom_reg;

    // coordinate split per octave
    logic     split_valid;
    lattice_t ix_w [OCTAVE_COUNT];
    lattice_t iz_w [OCTAVE_COUNT];
    logic signed [FRACTION_BITS:0] fx_w [OCTAVE_COUNT];
    logic signed [FRACTION_BITS:0] fz_w [OCTAVE_COUNT];

    fvnh_split #(
        .OCTAVE_COUNT  (OCTAVE_COUNT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_x      (column_x),
        .in_z      (column_z),
        .zoom      (zoom_eff),
        .out_valid (split_valid),
        .ix        (ix_w),
        .iz        (iz_w),
        .fx        (fx_w),
        .fz        (fz_w)
    );

    // octave units in parallel
    logic signed [FRACTION_BITS+1:0] oct_value [OCTAVE_COUNT];

    for (genvar k = 0; k < OCTAVE_COUNT; k++)
    begin : g_octave
        fvnh_octave #(
            .OCTAVE_INDEX      (k),
            .FRACTION_BITS     (FRACTION_BITS),
            .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
        ) u_octave (
            .clk   (clk),
            .ix    (ix_w[k]),
            .iz    (iz_w[k]),
            .fx    (fx_w[k]),
            .fz    (fz_w[k]),
            .seed  (seed_reg),
            .value (oct_value[k])
        );
    end

    // valid alongside the octave units
    logic oct_vld_reg [OCT_LATENCY];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < OCT_LATENCY; d++)
            begin
                oct_vld_reg[d] <= 1'b0;
            end
        end
        else
        begin
            oct_vld_reg[0] <= split_valid;
            for (int d = 1; d < OCT_LATENCY; d++)
            begin
                oct_vld_reg[d] <= oct_vld_reg[d-1];
            end
        end
    end

    // sum, scale and saturate
    fvnh_sum #(
        .OCTAVE_COUNT  (OCTAVE_COUNT),
        .FRACTION_BITS (FRACTION_BITS),
        .HEIGHT_SPAN   (HEIGHT_SPAN)
    ) u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (oct_vld_reg[OCT_LATENCY-1]),
        .values   (oct_value),
        .done     (done),
        .height   (terrain_height)
    );

endmodule
